>>> sv/rbd_pkg.sv
// Shared types, codes and defaults for the ring buffer deque.
package rbd_pkg;

    localparam int DEPTH_DEF  = 64;
    localparam int ELEM_W_DEF = 32;
    localparam int CMD_W      = 3;
    localparam int IDX_W      = 6;
    localparam int STATUS_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_READ_AT    = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2,
        STS_RANGE = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_WALK = 1'b1
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_WRITE = 2'd1,
        CELL_UP    = 2'd2,
        CELL_DOWN  = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     tap_load;
        logic     tap_shift;
    } t_cell_ctl;

endpackage

>>> sv/rbd_cmd_if.sv
// Command channel: valid/ready handshake with command payload.
interface rbd_cmd_if #(
    parameter int ELEMENT_WIDTH = rbd_pkg::ELEM_W_DEF
);
    logic                       valid;
    logic                       ready;
    logic [rbd_pkg::CMD_W-1:0]  command;
    logic [ELEMENT_WIDTH-1:0]   push_data;
    logic [rbd_pkg::IDX_W-1:0]  read_index;

    modport source (output valid, output command, output push_data, output read_index,
                    input ready);
    modport sink   (input valid, input command, input push_data, input read_index,
                    output ready);
endinterface

>>> sv/rbd_rsp_if.sv
// Result channel: valid/ready handshake with result payload.
interface rbd_rsp_if #(
    parameter int ELEMENT_WIDTH = rbd_pkg::ELEM_W_DEF,
    parameter int FILL_W        = $clog2(rbd_pkg::DEPTH_DEF + 1)
);
    logic                         valid;
    logic                         ready;
    logic [ELEMENT_WIDTH-1:0]     read_data;
    logic [FILL_W-1:0]            fill_count;
    logic [rbd_pkg::STATUS_W-1:0] status;

    modport source (output valid, output read_data, output fill_count, output status,
                    input ready);
    modport sink   (input valid, input read_data, input fill_count, input status,
                    output ready);
endinterface

>>> sv/rbd_cell.sv
// One storage cell of the deque chain, with its read-out tap stage.
module rbd_cell #(
    parameter int IDX = 0,
    parameter int PW  = 6,
    parameter int EW  = 32
) (
    input  logic               i_clk,
    input  rbd_pkg::t_cell_ctl i_ctl,
    input  logic [PW-1:0]      i_wr_pos,
    input  logic [EW-1:0]      i_push_data,
    input  logic [EW-1:0]      i_lo_data,
    input  logic [EW-1:0]      i_hi_data,
    input  logic [EW-1:0]      i_hi_tap,
    output logic [EW-1:0]      o_data,
    output logic [EW-1:0]      o_tap
);
    localparam logic [PW-1:0] POS = PW'(IDX);

    logic [EW-1:0] r_data, n_data;
    logic [EW-1:0] r_tap, n_tap;

    always_comb begin
        unique case (i_ctl.op)
            rbd_pkg::CELL_HOLD:  n_data = r_data;
            rbd_pkg::CELL_WRITE: n_data = (i_wr_pos == POS) ? i_push_data : r_data;
            rbd_pkg::CELL_UP:    n_data = i_lo_data;
            rbd_pkg::CELL_DOWN:  n_data = i_hi_data;
            default:             n_data = r_data;
        endcase
    end

    // tap chain moves toward the front cell, one place a cycle
    always_comb begin
        if (i_ctl.tap_load) begin
            n_tap = r_data;
        end else if (i_ctl.tap_shift) begin
            n_tap = i_hi_tap;
        end else begin
            n_tap = r_tap;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_tap  <= n_tap;
    end

    assign o_data = r_data;
    assign o_tap  = r_tap;
endmodule

>>> sv/rbd_ctrl.sv
// Deque controller: occupancy, command decode, read-out walk and result register.
module rbd_ctrl #(
    parameter int DEPTH         = rbd_pkg::DEPTH_DEF,
    parameter int ELEMENT_WIDTH = rbd_pkg::ELEM_W_DEF,
    parameter int PW            = $clog2(DEPTH),
    parameter int CW            = $clog2(DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    rbd_cmd_if.sink                  i_cmd,
    rbd_rsp_if.source                o_rsp,
    input  logic [ELEMENT_WIDTH-1:0] i_head_data,
    input  logic [ELEMENT_WIDTH-1:0] i_head_tap,
    output rbd_pkg::t_cell_ctl       o_ctl,
    output logic [PW-1:0]            o_wr_pos
);
    localparam int CMPW = (CW > rbd_pkg::IDX_W) ? CW : rbd_pkg::IDX_W;

    rbd_pkg::t_state  r_state, n_state;
    logic [CW-1:0]    r_occ, n_occ;
    logic [PW-1:0]    r_cnt, n_cnt;
    logic             r_pop_back, n_pop_back;

    logic                     r_rsp_valid, n_rsp_valid;
    logic [ELEMENT_WIDTH-1:0] r_rsp_data, n_rsp_data;
    logic [CW-1:0]            r_rsp_fill, n_rsp_fill;
    rbd_pkg::t_status         r_rsp_status, n_rsp_status;

    logic            w_ready;
    logic            w_acc;
    logic            w_walk;
    logic            w_full;
    logic            w_empty;
    logic            w_range;
    logic [CMPW-1:0] w_idx_c;
    logic [CMPW-1:0] w_occ_c;
    rbd_pkg::t_cmd   w_cmd;

    assign w_cmd   = rbd_pkg::t_cmd'(i_cmd.command);
    assign w_full  = (r_occ == CW'(DEPTH));
    assign w_empty = (r_occ == '0);
    assign w_idx_c = CMPW'(i_cmd.read_index);
    assign w_occ_c = CMPW'(r_occ);
    assign w_range = (w_idx_c >= w_occ_c);
    assign w_ready = (r_state == rbd_pkg::S_IDLE) && (!r_rsp_valid || o_rsp.ready);
    assign w_acc   = i_cmd.valid && w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rbd_pkg::S_IDLE;
            r_occ       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt        <= n_cnt;
        r_pop_back   <= n_pop_back;
        r_rsp_data   <= n_rsp_data;
        r_rsp_fill   <= n_rsp_fill;
        r_rsp_status <= n_rsp_status;
    end

    always_comb begin
        n_state        = r_state;
        n_occ          = r_occ;
        n_cnt          = r_cnt;
        n_pop_back     = r_pop_back;
        n_rsp_valid    = r_rsp_valid && !o_rsp.ready;
        n_rsp_data     = r_rsp_data;
        n_rsp_fill     = r_rsp_fill;
        n_rsp_status   = r_rsp_status;
        o_ctl.op        = rbd_pkg::CELL_HOLD;
        o_ctl.tap_load  = 1'b0;
        o_ctl.tap_shift = 1'b0;
        w_walk         = 1'b0;

        unique case (r_state)
            rbd_pkg::S_IDLE: begin
                if (w_acc) begin
                    n_rsp_valid  = 1'b1;
                    n_rsp_data   = '0;
                    n_rsp_fill   = r_occ;
                    n_rsp_status = rbd_pkg::STS_OK;
                    unique case (w_cmd) inside
                        rbd_pkg::CMD_PUSH_BACK, rbd_pkg::CMD_PUSH_FRONT: begin
                            if (w_full) begin
                                n_rsp_status = rbd_pkg::STS_FULL;
                            end else begin
                                o_ctl.op   = (w_cmd == rbd_pkg::CMD_PUSH_BACK) ?
                                             rbd_pkg::CELL_WRITE : rbd_pkg::CELL_UP;
                                n_occ      = r_occ + CW'(1);
                                n_rsp_fill = r_occ + CW'(1);
                            end
                        end
                        rbd_pkg::CMD_POP_FRONT: begin
                            if (w_empty) begin
                                n_rsp_status = rbd_pkg::STS_EMPTY;
                            end else begin
                                o_ctl.op   = rbd_pkg::CELL_DOWN;
                                n_rsp_data = i_head_data;
                                n_occ      = r_occ - CW'(1);
                                n_rsp_fill = r_occ - CW'(1);
                            end
                        end
                        rbd_pkg::CMD_POP_BACK: begin
                            if (w_empty) begin
                                n_rsp_status = rbd_pkg::STS_EMPTY;
                            end else begin
                                w_walk         = 1'b1;
                                n_rsp_valid    = r_rsp_valid && !o_rsp.ready;
                                o_ctl.tap_load = 1'b1;
                                n_cnt          = PW'(r_occ - CW'(1));
                                n_pop_back     = 1'b1;
                                n_state        = rbd_pkg::S_WALK;
                            end
                        end
                        rbd_pkg::CMD_READ_AT: begin
                            if (w_range) begin
                                n_rsp_status = rbd_pkg::STS_RANGE;
                            end else begin
                                w_walk         = 1'b1;
                                n_rsp_valid    = r_rsp_valid && !o_rsp.ready;
                                o_ctl.tap_load = 1'b1;
                                n_cnt          = PW'(w_idx_c);
                                n_pop_back     = 1'b0;
                                n_state        = rbd_pkg::S_WALK;
                            end
                        end
                        default: begin
                            // unused codes: plain ok result, nothing moves
                        end
                    endcase
                end
            end
            rbd_pkg::S_WALK: begin
                if (r_cnt == '0) begin
                    n_rsp_valid  = 1'b1;
                    n_rsp_data   = i_head_tap;
                    n_rsp_status = rbd_pkg::STS_OK;
                    n_rsp_fill   = r_pop_back ? (r_occ - CW'(1)) : r_occ;
                    n_occ        = r_pop_back ? (r_occ - CW'(1)) : r_occ;
                    n_state      = rbd_pkg::S_IDLE;
                end else begin
                    o_ctl.tap_shift = 1'b1;
                    n_cnt           = r_cnt - PW'(1);
                end
            end
            default: n_state = rbd_pkg::S_IDLE;
        endcase
    end

    assign o_wr_pos         = PW'(r_occ);
    assign i_cmd.ready      = w_ready;
    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.read_data  = r_rsp_data;
    assign o_rsp.fill_count = r_rsp_fill;
    assign o_rsp.status     = r_rsp_status;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(DEPTH))
        else $error("occupancy above depth");

    a_walk_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rbd_pkg::S_WALK) |-> !i_cmd.ready)
        else $error("command taken during read-out walk");

    a_direct_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready && !w_walk) |=> o_rsp.valid)
        else $error("no result after direct command");

    a_walk_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rbd_pkg::S_WALK && r_cnt != '0) |=>
            (r_state == rbd_pkg::S_WALK && r_cnt == $past(r_cnt) - PW'(1)))
        else $error("walk counter out of step");
`endif
endmodule

>>> sv/ring_buffer_deque_core.sv
// Top level of the ring buffer deque: controller and the chain of storage cells.
//
//   channel  direction  payload                            handshake
//   i_cmd    in         command, push_data, read_index     valid/ready
//   o_rsp    out        read_data, fill_count, status      valid/ready
//
// Pushes, pop-front, errors and unused codes complete in the accept cycle: the cells
// write one cell or shift the whole row and the result is valid in the next cycle.
// Pop-back and read-at-index read the element at position k from the front through
// the cells' tap chain: it is loaded, then shifted toward cell 0 once a cycle.
// Reset clears occupancy, state and result valid; cell contents are not reset.
// A new command is taken only when idle and the result register is empty or is
// being emptied in the same cycle; o_rsp stalls hold the result register.
module ring_buffer_deque_core #(
    parameter int DEPTH         = rbd_pkg::DEPTH_DEF,
    parameter int ELEMENT_WIDTH = rbd_pkg::ELEM_W_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rbd_cmd_if.sink   i_cmd,
    rbd_rsp_if.source o_rsp
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    rbd_pkg::t_cell_ctl       w_ctl;
    logic [PW-1:0]            w_wr_pos;
    logic [ELEMENT_WIDTH-1:0] w_data [DEPTH];
    logic [ELEMENT_WIDTH-1:0] w_tap  [DEPTH];

    rbd_ctrl #(
        .DEPTH         (DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH),
        .PW            (PW),
        .CW            (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_rsp       (o_rsp),
        .i_head_data (w_data[0]),
        .i_head_tap  (w_tap[0]),
        .o_ctl       (w_ctl),
        .o_wr_pos    (w_wr_pos)
    );

    // cell 0 is always the front of the queue
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [ELEMENT_WIDTH-1:0] w_lo;
        logic [ELEMENT_WIDTH-1:0] w_hi;
        logic [ELEMENT_WIDTH-1:0] w_hi_tap;

        if (g == 0) begin : g_first
            assign w_lo = i_cmd.push_data;
        end else begin : g_mid_lo
            assign w_lo = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_hi     = '0;
            assign w_hi_tap = '0;
        end else begin : g_mid_hi
            assign w_hi     = w_data[g+1];
            assign w_hi_tap = w_tap[g+1];
        end

        rbd_cell #(
            .IDX (g),
            .PW  (PW),
            .EW  (ELEMENT_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_wr_pos    (w_wr_pos),
            .i_push_data (i_cmd.push_data),
            .i_lo_data   (w_lo),
            .i_hi_data   (w_hi),
            .i_hi_tap    (w_hi_tap),
            .o_data      (w_data[g]),
            .o_tap       (w_tap[g])
        );
    end
endmodule

>>> bench/deque_result_check.sv
// Result checker for the ring buffer deque: predicts every result and compares it.
`timescale 1ns / 100ps

module deque_result_check #(
    parameter int DEPTH         = rbd_pkg::DEPTH_DEF,
    parameter int ELEMENT_WIDTH = rbd_pkg::ELEM_W_DEF,
    parameter int FILL_W        = $clog2(rbd_pkg::DEPTH_DEF + 1)
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rbd_cmd_if   i_cmd,
    rbd_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [ELEMENT_WIDTH-1:0] read_data;
        logic [FILL_W-1:0]        fill_count;
        rbd_pkg::t_status         status;
    } deque_result_t;

    // shadow deque; only slots inside the fill level are ever read
    logic [ELEMENT_WIDTH-1:0] deque_mem [DEPTH];
    int                       front_ptr  = 0;
    int                       fill_level = 0;
    int                       fail_total = 0;
    deque_result_t            awaited_results [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic deque_result_t apply_deque_cmd(
        input logic [rbd_pkg::CMD_W-1:0] op,
        input logic [ELEMENT_WIDTH-1:0]  data,
        input logic [rbd_pkg::IDX_W-1:0] idx
    );
        deque_result_t res;
        res.read_data = '0;
        res.status    = rbd_pkg::STS_OK;
        case (op)
            rbd_pkg::CMD_PUSH_BACK: begin
                if (fill_level >= DEPTH) begin
                    res.status = rbd_pkg::STS_FULL;
                end else begin
                    deque_mem[(front_ptr + fill_level) % DEPTH] = data;
                    fill_level++;
                end
            end
            rbd_pkg::CMD_PUSH_FRONT: begin
                if (fill_level >= DEPTH) begin
                    res.status = rbd_pkg::STS_FULL;
                end else begin
                    front_ptr = (front_ptr + DEPTH - 1) % DEPTH;
                    deque_mem[front_ptr] = data;
                    fill_level++;
                end
            end
            rbd_pkg::CMD_POP_BACK: begin
                if (fill_level == 0) begin
                    res.status = rbd_pkg::STS_EMPTY;
                end else begin
                    fill_level--;
                    res.read_data = deque_mem[(front_ptr + fill_level) % DEPTH];
                end
            end
            rbd_pkg::CMD_POP_FRONT: begin
                if (fill_level == 0) begin
                    res.status = rbd_pkg::STS_EMPTY;
                end else begin
                    res.read_data = deque_mem[front_ptr];
                    front_ptr = (front_ptr + 1) % DEPTH;
                    fill_level--;
                end
            end
            rbd_pkg::CMD_READ_AT: begin
                if (int'(idx) >= fill_level) begin
                    res.status = rbd_pkg::STS_RANGE;
                end else begin
                    res.read_data = deque_mem[(front_ptr + int'(idx)) % DEPTH];
                end
            end
            default: ;  // spare codes leave everything as it is
        endcase
        res.fill_count = FILL_W'(fill_level);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: deque %s: got %0h, expected %0h", $time, what, got, want);
        fail_total++;
    endtask

    always @(posedge i_clk) begin : watch
        deque_result_t want;
        if (!i_rst_n) begin
            front_ptr  = 0;
            fill_level = 0;
            awaited_results.delete();
        end else begin
            // a result can never belong to a command taken on the same edge
            if (i_rsp.valid === 1'b1 && i_rsp.ready === 1'b1) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with nothing awaited", 64'(i_rsp.read_data), 0);
                end else begin
                    want = awaited_results.pop_front();
                    if (i_rsp.read_data !== want.read_data)
                        report_mismatch("read_data", 64'(i_rsp.read_data),
                                        64'(want.read_data));
                    if (i_rsp.fill_count !== want.fill_count)
                        report_mismatch("fill_count", 64'(i_rsp.fill_count),
                                        64'(want.fill_count));
                    if (i_rsp.status !== want.status)
                        report_mismatch("status", 64'(i_rsp.status), 64'(want.status));
                end
            end
            if (i_cmd.valid === 1'b1 && i_cmd.ready === 1'b1)
                awaited_results.push_back(apply_deque_cmd(i_cmd.command, i_cmd.push_data,
                                                          i_cmd.read_index));
        end
        o_fail_count <= fail_total;
        o_pending    <= awaited_results.size();
    end

endmodule

>>> bench/ring_buffer_deque_core_tb.sv
// Top of the ring buffer deque bench: clock, reset, command traffic and verdict.
`timescale 1ns / 100ps

module ring_buffer_deque_core_tb;

    localparam int DEPTH          = rbd_pkg::DEPTH_DEF;
    localparam int ELEMENT_WIDTH  = rbd_pkg::ELEM_W_DEF;
    localparam int FILL_W         = $clog2(DEPTH + 1);
    localparam int RANDOM_ITEMS   = 1700;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 2 * DEPTH + 16;
    localparam int WATCHDOG_LIMIT = 5000;

    // unused codes: the block answers them with a plain ok result
    localparam logic [rbd_pkg::CMD_W-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [rbd_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [rbd_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_MIX,
        PH_READ,
        PH_NOISE
    } phase_kind_t;

    logic i_clk;
    logic i_rst_n;
    logic rsp_hold;
    bit   pressure_go;
    int   fail_count;
    int   pending;
    int   stim_fill;
    int   items_sent;
    int   cmd_idle_pct;
    int   rsp_stall_pct;
    int   idle_cycles;

    rbd_cmd_if #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) cmd_ch ();
    rbd_rsp_if #(.ELEMENT_WIDTH(ELEMENT_WIDTH), .FILL_W(FILL_W)) rsp_ch ();

    ring_buffer_deque_core #(
        .DEPTH        (DEPTH),
        .ELEMENT_WIDTH(ELEMENT_WIDTH)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch),
        .o_rsp  (rsp_ch)
    );

    deque_result_check #(
        .DEPTH        (DEPTH),
        .ELEMENT_WIDTH(ELEMENT_WIDTH),
        .FILL_W       (FILL_W)
    ) u_result_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_ch),
        .i_rsp       (rsp_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly short idle stretches, now and then a long one
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_cmd(input logic [rbd_pkg::CMD_W-1:0] op,
                            input logic [ELEMENT_WIDTH-1:0] data,
                            input logic [rbd_pkg::IDX_W-1:0] idx);
        int gap;
        gap = 0;
        if (cmd_idle_pct > 0 && $urandom_range(0, 99) < cmd_idle_pct)
            gap = pick_idle_len();
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.command    <= op;
        cmd_ch.push_data  <= data;
        cmd_ch.read_index <= idx;
        @(posedge i_clk);
        while (cmd_ch.ready !== 1'b1) @(posedge i_clk);
        // rough occupancy, only to steer the stimulus
        case (op)
            rbd_pkg::CMD_PUSH_BACK, rbd_pkg::CMD_PUSH_FRONT:
                if (stim_fill < DEPTH) stim_fill++;
            rbd_pkg::CMD_POP_BACK, rbd_pkg::CMD_POP_FRONT:
                if (stim_fill > 0) stim_fill--;
            default: ;
        endcase
        if (op <= rbd_pkg::CMD_READ_AT) items_sent++;
    endtask

    task automatic send_random(input logic [rbd_pkg::CMD_W-1:0] op);
        logic [ELEMENT_WIDTH-1:0]  data;
        logic [rbd_pkg::IDX_W-1:0] idx;
        int                        r;
        r = $urandom_range(0, 99);
        if (r < 5) data = '0;
        else if (r < 10) data = '1;
        else data = ELEMENT_WIDTH'($urandom);
        if (stim_fill > 0 && $urandom_range(0, 99) < 85)
            idx = rbd_pkg::IDX_W'($urandom_range(0, stim_fill - 1));
        else
            idx = rbd_pkg::IDX_W'($urandom_range(0, DEPTH - 1));
        send_cmd(op, data, idx);
    endtask

    function automatic logic [rbd_pkg::CMD_W-1:0] pick_push();
        return $urandom_range(0, 1) ? rbd_pkg::CMD_PUSH_FRONT : rbd_pkg::CMD_PUSH_BACK;
    endfunction

    function automatic logic [rbd_pkg::CMD_W-1:0] pick_pop();
        return $urandom_range(0, 1) ? rbd_pkg::CMD_POP_FRONT : rbd_pkg::CMD_POP_BACK;
    endfunction

    // weights in percent for push and pop; the rest are indexed reads
    task automatic send_weighted(input int push_pct, input int pop_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct) send_random(pick_push());
        else if (r < push_pct + pop_pct) send_random(pick_pop());
        else send_random(rbd_pkg::CMD_READ_AT);
    endtask

    task automatic run_phase(input phase_kind_t kind);
        int extra;
        int n;
        int guard;
        extra = 0;
        guard = 0;
        n     = $urandom_range(2, 5);
        case (kind)
            PH_FILL: begin
                // up to full, then 2 to 5 more commands while full, whose pushes must be refused
                while (!(stim_fill == DEPTH && extra >= n) && guard < 600) begin
                    if (stim_fill == DEPTH) extra++;
                    send_weighted(75, 10);
                    guard++;
                end
            end
            PH_DRAIN: begin
                while (!(stim_fill == 0 && extra >= n) && guard < 600) begin
                    if (stim_fill == 0) extra++;
                    send_weighted(10, 75);
                    guard++;
                end
            end
            PH_MIX:  repeat (100) send_weighted(35, 35);
            PH_READ: repeat (100) send_weighted(15, 15);
            default: begin
                repeat (60)
                    send_cmd(rbd_pkg::CMD_W'($urandom_range(0, 7)), ELEMENT_WIDTH'($urandom),
                             rbd_pkg::IDX_W'($urandom_range(0, DEPTH - 1)));
            end
        endcase
    endtask

    task automatic pick_idling();
        if ($urandom_range(0, 3) == 0) begin
            cmd_idle_pct  = 0;
            rsp_stall_pct = 0;
        end else begin
            cmd_idle_pct  = $urandom_range(10, 50);
            rsp_stall_pct = $urandom_range(10, 50);
        end
    endtask

    // receiver side: random stalls plus the long hold-off
    initial begin : rsp_ready_drive
        int stall_left;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0)
                stall_left--;
            else if (rsp_stall_pct > 0 && $urandom_range(0, 99) < rsp_stall_pct)
                stall_left = pick_idle_len();
            rsp_ch.ready <= !rsp_hold && stall_left == 0;
        end
    end

    initial begin : rsp_pressure
        rsp_hold <= 1'b0;
        wait (pressure_go);
        @(posedge i_clk);
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rsp_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ring_buffer_deque_core_tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int r;
        idle_cycles   = 0;
        stim_fill     = 0;
        items_sent    = 0;
        pressure_go   = 1'b0;
        cmd_idle_pct  = 0;
        rsp_stall_pct = 0;
        i_rst_n           <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.command    <= rbd_pkg::CMD_PUSH_BACK;
        cmd_ch.push_data  <= '0;
        cmd_ch.read_index <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty errors, field extremes, both ends, spare codes
        cmd_idle_pct  = 20;
        rsp_stall_pct = 20;
        send_cmd(rbd_pkg::CMD_POP_BACK,   '0, '0);
        send_cmd(rbd_pkg::CMD_POP_FRONT,  '1, '1);
        send_cmd(rbd_pkg::CMD_READ_AT,    '0, '0);
        send_cmd(rbd_pkg::CMD_READ_AT,    '0, '1);
        send_cmd(rbd_pkg::CMD_PUSH_BACK,  '0, '1);
        send_cmd(rbd_pkg::CMD_PUSH_FRONT, '1, '0);
        send_cmd(rbd_pkg::CMD_PUSH_BACK,  32'ha5a5_5a5a, '0);
        send_cmd(rbd_pkg::CMD_READ_AT,    '0, 6'd0);
        send_cmd(rbd_pkg::CMD_READ_AT,    '0, 6'd1);
        send_cmd(rbd_pkg::CMD_READ_AT,    '0, 6'd2);
        send_cmd(rbd_pkg::CMD_READ_AT,    '0, 6'd3);
        send_cmd(rbd_pkg::CMD_READ_AT,    '1, '1);
        send_cmd(CMD_SPARE_5,             32'h1234_5678, 6'd1);
        send_cmd(CMD_SPARE_6,             '0, '0);
        send_cmd(CMD_SPARE_7,             '1, '1);
        send_cmd(rbd_pkg::CMD_POP_FRONT,  '0, '0);
        send_cmd(rbd_pkg::CMD_POP_BACK,   '0, '0);
        send_cmd(rbd_pkg::CMD_POP_BACK,   '0, '0);
        send_cmd(rbd_pkg::CMD_POP_FRONT,  '0, '0);
        send_cmd(rbd_pkg::CMD_PUSH_FRONT, 32'h8000_0001, '0);
        send_cmd(rbd_pkg::CMD_POP_FRONT,  '0, '0);
        send_cmd(rbd_pkg::CMD_PUSH_BACK,  32'h0000_0001, '0);
        send_cmd(rbd_pkg::CMD_POP_BACK,   '0, '0);

        // random: start by filling while the receiver holds off
        items_sent  = 0;
        pressure_go = 1'b1;
        pick_idling();
        run_phase(PH_FILL);
        while (items_sent < RANDOM_ITEMS) begin
            pick_idling();
            r = $urandom_range(0, 99);
            if (r < 20) run_phase(PH_FILL);
            else if (r < 40) run_phase(PH_DRAIN);
            else if (r < 70) run_phase(PH_MIX);
            else if (r < 90) run_phase(PH_READ);
            else run_phase(PH_NOISE);
        end
        cmd_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ring_buffer_deque_core_tb passed");
        end else begin
            $display("ring_buffer_deque_core_tb failed");
        end
        $finish;
    end

endmodule
